FILE: rtl/core/positional_char_list_core_macros.svh
// Assertion macros shared by the list core RTL.
`ifndef POSITIONAL_CHAR_LIST_CORE_MACROS_SVH
`define POSITIONAL_CHAR_LIST_CORE_MACROS_SVH

// Check an invariant at every clock edge outside reset.
`define PCL_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define PCL_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/pcl_pkg.sv
// Shared types and constants for the positional byte list core.
package pcl_pkg;

   localparam int PCL_CAPACITY = 64;
   localparam int BYTE_W       = 8;
   localparam int POS_W        = 6;
   localparam int OP_W         = 3;
   localparam int CNT_OUT_W    = 7;
   localparam int STATUS_W     = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_APPEND       = 3'd0;
   localparam logic [OP_W-1:0] OP_PREPEND      = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT       = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE       = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE_FIRST = 3'd4;
   localparam logic [OP_W-1:0] OP_READ         = 3'd5;
   localparam logic [OP_W-1:0] OP_CLEAR        = 3'd6;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [POS_W-1:0]  position;
      logic [BYTE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    read_byte;
      logic [CNT_OUT_W-1:0] item_count;
      logic [STATUS_W-1:0]  status;
   } rsp_type;

endpackage

FILE: rtl/core/pcl_store.sv
// Byte storage for the list: one write port, one registered read port.
module pcl_store
   import pcl_pkg::*;
#(
   parameter int DEPTH = PCL_CAPACITY,
   parameter int AW    = $clog2(PCL_CAPACITY)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // write one entry, read one entry into the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/positional_char_list_core.sv
// Positional byte list core: sequencer, range checks and result register.
// Sequence: append, clear, unused and refused codes go from S_IDLE straight to S_FINISH; read
// passes through S_READ; insert and remove pass through S_SHIFT, which moves the entries first.
// Throughput: one item at a time; req_stall is low again at the edge that loads the result,
// so the next beat can be taken in the cycle after that; a stalled result holds the sequencer.
// Reset: clears the count, sequencer and result valid; stored bytes are not cleared.
module positional_char_list_core
   import pcl_pkg::*;
#(
   parameter int CAPACITY = PCL_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

`include "positional_char_list_core_macros.svh"

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CW-1:0] CNT_CAP = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SHIFT  = 4'b0010,
      S_READ   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic [CW-1:0] p_ff, p_in;
   logic          ins_ff, ins_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_dst_ff, pend_dst_in;
   logic [BYTE_W-1:0]   val_ff, val_in;
   logic [BYTE_W-1:0]   res_byte_ff, res_byte_in;
   logic [STATUS_W-1:0] stat_ff, stat_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr;
   logic [BYTE_W-1:0] rd_data;

   logic [CMPW-1:0] pos_ext, cnt_ext, ins_pos, rem_pos;
   logic            full, more, load_rsp;
   logic [CW-1:0]   cur_up, cur_dn, src;

   pcl_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // operand views for range checks
   assign pos_ext = CMPW'(req_data.position);
   assign cnt_ext = CMPW'(count_ff);
   assign full    = (count_ff == CNT_CAP);
   assign ins_pos = (req_data.operation == OP_PREPEND) ? '0 : pos_ext;
   assign rem_pos = (req_data.operation == OP_REMOVE_FIRST) ? '0 : pos_ext;

   // shift cursor: insert walks down from the end, remove walks up
   assign cur_up = cur_ff + ONE_C;
   assign cur_dn = cur_ff - ONE_C;
   assign src    = ins_ff ? cur_dn : cur_up;
   assign more   = ins_ff ? (cur_ff > p_ff) : (cur_up < count_ff);

   // result register frees when empty or when its beat is taken
   assign load_rsp = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      cur_in      = cur_ff;
      p_in        = p_ff;
      ins_in      = ins_ff;
      pend_in     = 1'b0;
      pend_dst_in = pend_dst_ff;
      val_in      = val_ff;
      res_byte_in = res_byte_ff;
      stat_in     = stat_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      rd_addr     = '0;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in    = S_FINISH;
               res_byte_in = '0;
               stat_in     = ST_DONE;
               val_in      = req_data.value;
               unique case (req_data.operation) inside
                  OP_APPEND: begin
                     if (full) begin
                        stat_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = req_data.value;
                        count_in = count_ff + ONE_C;
                     end
                  end
                  OP_PREPEND, OP_INSERT: begin
                     if (full) begin
                        stat_in = ST_FULL;
                     end else if (ins_pos > cnt_ext) begin
                        stat_in = ST_RANGE;
                     end else begin
                        ins_in   = 1'b1;
                        p_in     = ins_pos[CW-1:0];
                        cur_in   = count_ff;
                        state_in = S_SHIFT;
                     end
                  end
                  OP_REMOVE, OP_REMOVE_FIRST: begin
                     if (rem_pos >= cnt_ext) begin
                        stat_in = ST_RANGE;
                     end else begin
                        ins_in   = 1'b0;
                        p_in     = rem_pos[CW-1:0];
                        cur_in   = rem_pos[CW-1:0];
                        state_in = S_SHIFT;
                     end
                  end
                  OP_READ: begin
                     if (pos_ext >= cnt_ext) begin
                        stat_in = ST_RANGE;
                     end else begin
                        rd_addr  = pos_ext[AW-1:0];
                        state_in = S_READ;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SHIFT: begin
            // drain the move read in the previous cycle
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_dst_ff;
               wr_data = rd_data;
            end
            if (more) begin
               rd_addr     = src[AW-1:0];
               pend_in     = 1'b1;
               pend_dst_in = cur_ff[AW-1:0];
               cur_in      = src;
            end else if (!pend_ff) begin
               // all moves written: place the new byte or drop one entry
               if (ins_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = p_ff[AW-1:0];
                  wr_data  = val_ff;
                  count_in = count_ff + ONE_C;
               end else begin
                  count_in = count_ff - ONE_C;
               end
               state_in = S_FINISH;
            end
         end
         S_READ: begin
            res_byte_in = rd_data;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (load_rsp) begin
               rsp_data_in.read_byte  = res_byte_ff;
               rsp_data_in.item_count = CNT_OUT_W'(count_ff);
               rsp_data_in.status     = stat_ff;
               rsp_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      p_ff        <= p_in;
      ins_ff      <= ins_in;
      pend_dst_ff <= pend_dst_in;
      val_ff      <= val_in;
      res_byte_ff <= res_byte_in;
      stat_ff     <= stat_in;
      rsp_data_ff <= rsp_data_in;
   end

   `PCL_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_CAP, "count above capacity")
   `PCL_ASSERT_IMPLY(a_pend_in_shift, clock, reset, pend_ff, state_ff == S_SHIFT, "move pending outside shift")
   `PCL_ASSERT_IMPLY(a_write_state, clock, reset, wr_en, (state_ff == S_IDLE) || (state_ff == S_SHIFT), "store written in wrong state")
   `PCL_ASSERT_IMPLY(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_FINISH), "result beat without finish")
   `PCL_ASSERT_IMPLY(a_count_change, clock, reset, !$past(reset) && !$stable(count_ff), $past(state_ff == S_IDLE) || $past(state_ff == S_SHIFT), "count changed in wrong state")

endmodule

FILE: tb/tb.sv
// Self-checking bench for the positional byte list core: directed and random list operations.
`timescale 1ns / 1ps

module tb;
   import pcl_pkg::*;

   // opcode the core leaves unused; it still answers with a result
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

   localparam int RESET_CYCLES   = 9;
   localparam int RANDOM_ITEMS   = 250;   // per idling phase, five phases
   localparam int DRAIN_CYCLES   = PCL_CAPACITY + 16;
   localparam int WATCHDOG_LIMIT = 5000;

   // Mirror of the list contents; predicts one result per accepted beat.
   class byte_list_tracker;
      logic [BYTE_W-1:0] bytes [PCL_CAPACITY];
      int unsigned       count;
      rsp_type           pending_results[$];
      int unsigned       errors;

      function new();
         count  = 0;
         errors = 0;
      endfunction

      function int unsigned length();
         return count;
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      task report(string msg);
         $display("%0t ns: MISMATCH %s", $time, msg);
         errors++;
      endtask

      // Apply one accepted request to the mirror and queue its result.
      function void record_op(req_type r);
         rsp_type     res;
         int unsigned p;
         int unsigned i;
         bit          full;
         res            = '0;
         res.status     = ST_DONE;
         p              = 32'(r.position);
         full           = (count >= PCL_CAPACITY);
         case (r.operation) inside
            OP_APPEND: begin
               if (full) begin
                  res.status = ST_FULL;
               end else begin
                  bytes[count] = r.value;
                  count++;
               end
            end
            OP_PREPEND, OP_INSERT: begin
               if (r.operation == OP_PREPEND) p = 0;
               if (full) begin
                  res.status = ST_FULL;
               end else if (p > count) begin
                  res.status = ST_RANGE;
               end else begin
                  // open a gap at p, later bytes move up
                  for (i = count; i > p; i--) bytes[i] = bytes[i-1];
                  bytes[p] = r.value;
                  count++;
               end
            end
            OP_REMOVE, OP_REMOVE_FIRST: begin
               if (r.operation == OP_REMOVE_FIRST) p = 0;
               if (p >= count) begin
                  res.status = ST_RANGE;
               end else begin
                  // close the gap at p, later bytes move down
                  for (i = p; i + 1 < count; i++) bytes[i] = bytes[i+1];
                  count--;
               end
            end
            OP_READ: begin
               if (p >= count) res.status = ST_RANGE;
               else res.read_byte = bytes[p];
            end
            OP_CLEAR: begin
               count = 0;
            end
            default: begin
            end
         endcase
         res.item_count = CNT_OUT_W'(count);
         pending_results = {pending_results, res};
      endfunction

      // Compare one result beat with the oldest prediction.
      task compare_result(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result %h", got));
         end else begin
            want = pending_results[0];
            pending_results.delete(0);
            if (got.read_byte !== want.read_byte)
               report($sformatf("read_byte %h, expected %h", got.read_byte, want.read_byte));
            if (got.item_count !== want.item_count)
               report($sformatf("item_count %0d, expected %0d",
                                got.item_count, want.item_count));
            if (got.status !== want.status)
               report($sformatf("status %0d, expected %0d", got.status, want.status));
         end
      endtask
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned quiet_cycles   = 0;

   byte_list_tracker tracker = new();

   positional_char_list_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // stall the result channel at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // sample both channels and count cycles without progress
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tracker.record_op(req_data);
         if (rsp_valid && !rsp_stall) tracker.compare_result(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic req_type make_req(logic [OP_W-1:0] op, int unsigned pos,
                                        int unsigned val);
      req_type r;
      r.operation = op;
      r.position  = POS_W'(pos);
      r.value     = BYTE_W'(val);
      return r;
   endfunction

   // Pick a random request, mostly well formed for the current list length.
   function automatic req_type next_list_op(int unsigned cnt, bit growing);
      req_type     r;
      int unsigned roll;
      int unsigned grow_lim;
      int unsigned read_lim;
      r.value    = BYTE_W'($urandom_range(255));
      r.position = POS_W'($urandom_range(63));
      grow_lim   = growing ? 55 : 15;
      read_lim   = grow_lim + 25;
      roll       = $urandom_range(99);
      if (roll < 2) begin
         r.operation = OP_UNUSED;
      end else if (!growing && roll < 4) begin
         r.operation = OP_CLEAR;
      end else begin
         roll = $urandom_range(99);
         if (roll < grow_lim) begin
            case ($urandom_range(2))
               0: r.operation = OP_APPEND;
               1: r.operation = OP_PREPEND;
               default: r.operation = OP_INSERT;
            endcase
         end else if (roll < read_lim) begin
            r.operation = OP_READ;
         end else begin
            r.operation = $urandom_range(1) ? OP_REMOVE : OP_REMOVE_FIRST;
         end
         // keep most positions inside the list
         if ($urandom_range(99) < 85) begin
            if (r.operation == OP_INSERT)
               r.position = (cnt > 63) ? POS_W'($urandom_range(63)) : POS_W'($urandom_range(cnt));
            else if (cnt > 0)
               r.position = POS_W'($urandom_range(cnt - 1));
         end
      end
      return r;
   endfunction

   // Present one beat, idling first at the current rate; return at the next falling edge.
   task automatic send_item(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int unsigned idle_plan [5];
      int unsigned stall_plan[5];
      int unsigned ph;
      int unsigned n;
      bit          growing;
      req_type     r;
      idle_plan  = '{0, 65, 0, 20, 0};
      stall_plan = '{0, 0, 65, 20, 0};
      growing    = 1'b1;

      // hold reset, release on a falling edge
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty list, edges of positions, every operation
      send_item(make_req(OP_READ, 0, 0));
      send_item(make_req(OP_REMOVE_FIRST, 0, 0));
      send_item(make_req(OP_REMOVE, 0, 0));
      send_item(make_req(OP_CLEAR, 0, 0));
      send_item(make_req(OP_UNUSED, 63, 255));
      send_item(make_req(OP_INSERT, 1, 17));
      send_item(make_req(OP_INSERT, 0, 255));
      send_item(make_req(OP_APPEND, 0, 0));
      send_item(make_req(OP_PREPEND, 63, 165));
      send_item(make_req(OP_INSERT, 3, 90));
      send_item(make_req(OP_INSERT, 1, 60));
      send_item(make_req(OP_INSERT, 63, 1));
      send_item(make_req(OP_READ, 0, 0));
      send_item(make_req(OP_READ, 4, 0));
      send_item(make_req(OP_READ, 5, 0));
      send_item(make_req(OP_READ, 63, 0));
      send_item(make_req(OP_REMOVE, 2, 0));
      send_item(make_req(OP_REMOVE_FIRST, 0, 0));
      send_item(make_req(OP_REMOVE, 63, 0));
      send_item(make_req(OP_REMOVE, 2, 0));
      send_item(make_req(OP_READ, 1, 0));
      send_item(make_req(OP_CLEAR, 0, 0));
      send_item(make_req(OP_READ, 0, 0));

      // random: fill toward full, then drain toward empty, across idling phases
      for (ph = 0; ph < 5; ph++) begin
         send_idle_pct  = idle_plan[ph];
         recv_stall_pct = stall_plan[ph];
         n = 0;
         while (n < RANDOM_ITEMS) begin
            if (growing && tracker.length() >= PCL_CAPACITY && $urandom_range(5) == 0)
               growing = 1'b0;
            else if (!growing && tracker.length() == 0 && $urandom_range(2) == 0)
               growing = 1'b1;
            r = next_list_op(tracker.length(), growing);
            send_item(r);
            if (r.operation != OP_UNUSED) n++;
         end
      end
      req_valid <= 1'b0;

      // drain outstanding results, then let the core settle
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: positional_char_list_core.f
+incdir+rtl/core
rtl/core/pcl_pkg.sv
rtl/core/pcl_store.sv
rtl/core/positional_char_list_core.sv
tb/tb.sv
